### rtl/core/fir_pkg.sv
// Shared types, codes and helper functions for the firmware image receiver.
// Has no dependencies; every module of the block imports it.
package fir_pkg;

    // Header layout: three magic bytes, one protocol byte, four size bytes.
    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned HDR_CNT_W    = 4;
    localparam int unsigned MAGIC_BYTES  = 3;
    localparam int unsigned SIZE_START   = 4;
    localparam int unsigned CRC_BYTES    = 4;

    localparam logic [7:0] MAGIC_0 = 8'hD1;
    localparam logic [7:0] MAGIC_1 = 8'h36;
    localparam logic [7:0] MAGIC_2 = 8'h4A;

    // Reflected CRC-32 polynomial.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Event codes on the input channel.
    localparam logic [1:0] OP_CONNECT = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_ABORT   = 2'd2;
    localparam logic [1:0] OP_CLOSE   = 2'd3;

    // Transfer phases.
    localparam logic [2:0] PH_LISTEN = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_WRITE  = 3'd2;
    localparam logic [2:0] PH_CRCW   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    // Reply codes.
    localparam logic [2:0] RC_NONE = 3'd0;
    localparam logic [2:0] RC_HD   = 3'd1;
    localparam logic [2:0] RC_OK   = 3'd2;
    localparam logic [2:0] RC_ER   = 3'd3;
    localparam logic [2:0] RC_CC   = 3'd4;

    // Configuration register indexes (byte address bits [3:2]).
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_PART_OFFSET = 2'd0;
    localparam logic [1:0] REG_PART_BYTES  = 2'd1;
    localparam logic [1:0] REG_TARGET_OK   = 2'd2;

    // One input transaction.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  reply_code;
        logic        erase_request;
        logic        write_valid;
        logic [31:0] write_offset;
        logic [7:0]  write_byte;
        logic        drop_link;
        logic        reboot_request;
        logic [2:0]  phase_now;
    } t_out_item;

    // Classified event as it sits in the queue between front and back.
    typedef struct packed {
        logic       is_connect;
        logic       is_data;
        logic       is_abort;
        logic       is_close;
        logic [7:0] data;
    } t_cmd;

    // Expected magic byte for a header position below MAGIC_BYTES.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            default: m = MAGIC_2;
        endcase
        return m;
    endfunction

    // Advance a finished (inverted) CRC-32 value by one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

endpackage

### rtl/core/fir_front.sv
// Front end of the firmware image receiver: accepts input transactions,
// decodes the event code and queues them in a two-entry FIFO. Uses fir_pkg.
module fir_front
    import fir_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    logic       full;
    t_cmd       cmd_in;

    // Decode the event code into one flag per kind.
    always_comb begin
        cmd_in.is_connect = (i_in_item.op == OP_CONNECT);
        cmd_in.is_data    = (i_in_item.op == OP_DATA);
        cmd_in.is_abort   = (i_in_item.op == OP_ABORT);
        cmd_in.is_close   = (i_in_item.op == OP_CLOSE);
        cmd_in.data       = i_in_item.data_byte;
    end

    assign full        = (r_count == 2'd2);
    assign push        = i_in_valid && !full;
    assign o_in_stall  = full;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !i_cmd_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Queue storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

### rtl/core/fir_back.sv
// Back end of the firmware image receiver: runs the transfer state machine,
// the CRC-32 and the write address, and holds the result register. Uses fir_pkg.
module fir_back
    import fir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_partition_offset,
    input  logic [31:0] i_partition_bytes,
    input  logic        i_target_ok,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall
);

    logic [2:0]           r_phase;
    logic [HDR_CNT_W-1:0] r_header_count;
    logic                 r_magic_bad;
    logic [31:0]          r_image_size;
    logic [31:0]          r_bytes_written;
    logic [31:0]          r_crc_running;
    logic [2:0]           r_crc_count;
    logic [31:0]          r_crc_expected;
    logic                 r_reboot_sent;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic [2:0]           n_phase;
    logic [HDR_CNT_W-1:0] n_header_count;
    logic                 n_magic_bad;
    logic [31:0]          n_image_size;
    logic [31:0]          n_bytes_written;
    logic [31:0]          n_crc_running;
    logic [2:0]           n_crc_count;
    logic [31:0]          n_crc_expected;
    logic                 n_reboot_sent;
    t_out_item            n_out_item;

    logic [HDR_CNT_W-1:0] hc_inc;
    logic [31:0]          bw_inc;
    logic [31:0]          wr_off;
    logic [31:0]          crc_next;
    logic [2:0]           cc_inc;
    logic [31:0]          exp_next;

    // Take the next transaction whenever the result register is free or draining.
    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign hc_inc   = r_header_count + HDR_CNT_W'(1);
    assign bw_inc   = r_bytes_written + 32'd1;
    assign wr_off   = i_partition_offset + r_bytes_written;
    assign crc_next = crc_byte(r_crc_running, i_cmd.data);
    assign cc_inc   = r_crc_count + 3'd1;
    assign exp_next = {r_crc_expected[23:0], i_cmd.data};

    // Next state and result for the transaction at the head of the queue.
    always_comb begin
        n_phase         = r_phase;
        n_header_count  = r_header_count;
        n_magic_bad     = r_magic_bad;
        n_image_size    = r_image_size;
        n_bytes_written = r_bytes_written;
        n_crc_running   = r_crc_running;
        n_crc_count     = r_crc_count;
        n_crc_expected  = r_crc_expected;
        n_reboot_sent   = r_reboot_sent;
        n_out_item      = '0;

        if (i_cmd.is_connect) begin
            n_phase         = PH_HEADER;
            n_header_count  = '0;
            n_magic_bad     = 1'b0;
            n_bytes_written = '0;
            n_crc_running   = '0;
            n_crc_count     = '0;
        end else if (i_cmd.is_data) begin
            case (r_phase)
                PH_HEADER: begin
                    // Magic bytes are checked, size bytes shifted in big-endian.
                    if (r_header_count < HDR_CNT_W'(MAGIC_BYTES)) begin
                        if (i_cmd.data != magic_byte(r_header_count[1:0])) begin
                            n_magic_bad = 1'b1;
                        end
                    end else if (r_header_count >= HDR_CNT_W'(SIZE_START)) begin
                        n_image_size = {r_image_size[23:0], i_cmd.data};
                    end
                    n_header_count = hc_inc;
                    if (hc_inc >= HDR_CNT_W'(HEADER_BYTES)) begin
                        n_header_count = '0;
                        if (n_magic_bad || !i_target_ok) begin
                            n_out_item.reply_code = RC_ER;
                            n_out_item.drop_link  = 1'b1;
                            n_phase               = PH_ERROR;
                        end else begin
                            n_out_item.reply_code    = RC_HD;
                            n_out_item.erase_request = 1'b1;
                            n_phase                  = PH_WRITE;
                        end
                    end
                end
                PH_WRITE: begin
                    // Bound check against the partition, then program and hash.
                    if (r_bytes_written >= i_partition_bytes) begin
                        n_out_item.reply_code = RC_ER;
                        n_out_item.drop_link  = 1'b1;
                        n_phase               = PH_ERROR;
                    end else begin
                        n_out_item.write_valid  = 1'b1;
                        n_out_item.write_offset = wr_off;
                        n_out_item.write_byte   = i_cmd.data;
                        n_crc_running           = crc_next;
                        n_bytes_written         = bw_inc;
                        if (bw_inc == r_image_size) begin
                            n_out_item.reply_code = RC_OK;
                            n_phase               = PH_CRCW;
                            n_crc_count           = '0;
                        end
                    end
                end
                PH_CRCW: begin
                    // Collect the big-endian CRC and compare after its last byte.
                    n_crc_expected = exp_next;
                    n_crc_count    = cc_inc;
                    if (cc_inc >= 3'(CRC_BYTES)) begin
                        n_crc_count          = '0;
                        n_out_item.drop_link = 1'b1;
                        if (exp_next == r_crc_running) begin
                            n_out_item.reply_code = RC_CC;
                            n_phase               = PH_DONE;
                        end else begin
                            n_out_item.reply_code = RC_ER;
                            n_phase               = PH_ERROR;
                        end
                    end
                end
                default: begin
                    // Data while listening, done or in error is ignored.
                end
            endcase
        end else if (i_cmd.is_abort) begin
            n_out_item.drop_link = 1'b1;
            n_phase              = PH_ERROR;
        end else begin
            // Socket closed: first close after success asks for a reboot; any other close returns to listening.
            if (r_phase == PH_DONE && !r_reboot_sent) begin
                n_reboot_sent             = 1'b1;
                n_out_item.reboot_request = 1'b1;
            end else begin
                n_phase         = PH_LISTEN;
                n_bytes_written = '0;
                n_crc_running   = '0;
                n_crc_count     = '0;
            end
        end

        n_out_item.phase_now = n_phase;
    end

    // Transfer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_LISTEN;
            r_header_count  <= '0;
            r_magic_bad     <= 1'b0;
            r_image_size    <= '0;
            r_bytes_written <= '0;
            r_crc_running   <= '0;
            r_crc_count     <= '0;
            r_crc_expected  <= '0;
            r_reboot_sent   <= 1'b0;
        end else if (o_cmd_pop) begin
            r_phase         <= n_phase;
            r_header_count  <= n_header_count;
            r_magic_bad     <= n_magic_bad;
            r_image_size    <= n_image_size;
            r_bytes_written <= n_bytes_written;
            r_crc_running   <= n_crc_running;
            r_crc_count     <= n_crc_count;
            r_crc_expected  <= n_crc_expected;
            r_reboot_sent   <= n_reboot_sent;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

### rtl/core/firmware_image_receiver.sv
// Top level of the firmware image receiver: configuration registers on an
// APB-style port, the front-end queue and the back-end state machine. Uses fir_pkg.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_stall   | t_in_item  (op, data_byte)
//  out      | output    | o_out_valid / i_out_stall | t_out_item (reply and write)
//  config   | input     | psel / penable / pready   | paddr, pwdata, prdata
//
// One transaction is taken per cycle while the queue is not full; each gives exactly one result.
// A transaction accepted into the queue is then taken by the back end, which
// holds its result in the result register; the queue and the result register
// lie between an input and its result.
// The CRC-32 advances one byte per cycle while results are not stalled, in a single combinational step.
// Reset is synchronous and active low; it clears the queue, the state and the
// configuration registers. A stalled output holds its result and the queue
// keeps taking input until both entries are full.
module firmware_image_receiver
    import fir_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_item,
    input  logic               i_out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] r_partition_offset;
    logic [31:0] r_partition_bytes;
    logic        r_target_ok;
    logic        cfg_write;
    logic        cmd_valid;
    logic        cmd_pop;
    t_cmd        cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partition_offset <= '0;
            r_partition_bytes  <= '0;
            r_target_ok        <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_PART_OFFSET: r_partition_offset <= pwdata;
                REG_PART_BYTES:  r_partition_bytes  <= pwdata;
                REG_TARGET_OK:   r_target_ok        <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_PART_OFFSET: prdata = r_partition_offset;
            REG_PART_BYTES:  prdata = r_partition_bytes;
            REG_TARGET_OK:   prdata = {31'h0, r_target_ok};
            default:         prdata = '0;
        endcase
    end

    fir_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    fir_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_partition_offset (r_partition_offset),
        .i_partition_bytes  (r_partition_bytes),
        .i_target_ok        (r_target_ok),
        .i_cmd_valid        (cmd_valid),
        .i_cmd              (cmd),
        .o_cmd_pop          (cmd_pop),
        .o_out_valid        (o_out_valid),
        .o_out_item         (o_out_item),
        .i_out_stall        (i_out_stall)
    );

endmodule

### rtl/core/fir_checker.sv
// Port-level checks for the firmware image receiver, bound to the top level.
// Uses fir_pkg for the reply and phase codes.
module fir_checker
    import fir_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_item o_out_item,
    input logic      i_out_stall
);

    // A stalled result transaction holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // An erase only comes with the HD reply and the start of writing.
    a_erase_hd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.erase_request |->
            o_out_item.reply_code == RC_HD && o_out_item.phase_now == PH_WRITE)
        else $error("erase without header completion");

    // A reboot request leaves the transfer in the done phase.
    a_reboot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.reboot_request |->
            o_out_item.phase_now == PH_DONE && o_out_item.reply_code == RC_NONE)
        else $error("reboot request outside done");

    // Without a write the write address and data read as zero.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.write_valid |->
            o_out_item.write_offset == 32'h0 && o_out_item.write_byte == 8'h0)
        else $error("write fields set without a write");

    // A flash write happens only while the image is being received.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.write_valid |->
            o_out_item.phase_now == PH_WRITE || o_out_item.phase_now == PH_CRCW)
        else $error("flash write outside the writing phase");

endmodule

bind firmware_image_receiver fir_checker u_fir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

### tb/tb_firmware_image_receiver.sv
// Self-checking testbench for the firmware image receiver: feeds event transactions,
// predicts every result in step with the design and compares field by field.
// Depends on fir_pkg and the firmware_image_receiver top level only.
module tb_firmware_image_receiver;
    import fir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [23:0] MAGIC_SEQ = {MAGIC_0, MAGIC_1, MAGIC_2};

    // Clock, reset and every input of the block start at known values.
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    t_in_item           i_in_item  = '0;
    logic               i_out_stall = 1'b0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [31:0]        pwdata     = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_item;
    logic [31:0]        prdata;
    logic               pready;

    firmware_image_receiver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Events waiting to be sent and results the design still owes.
    t_in_item  tx_backlog[$];
    t_out_item predicted_out[$];

    // Shadow copy of the configuration registers.
    logic [31:0] cfg_offset = '0;
    logic [31:0] cfg_bytes  = '0;
    logic        cfg_target = 1'b0;

    // Transfer state as the design should hold it.
    logic [2:0]  st_phase      = PH_LISTEN;
    logic [3:0]  st_hdr_cnt    = '0;
    logic        st_magic_bad  = 1'b0;
    logic [31:0] st_size       = '0;
    logic [31:0] st_written    = '0;
    logic [31:0] st_crc        = '0;
    logic [2:0]  st_crc_cnt    = '0;
    logic [31:0] st_crc_exp    = '0;
    logic        st_reboot_sent = 1'b0;

    int cycle_count = 0;
    int queued_n    = 0;
    int accepted_n  = 0;
    int results_n   = 0;
    int mismatches  = 0;
    int settings_n  = 0;
    int hd_n = 0, ok_n = 0, cc_n = 0, er_n = 0, writes_n = 0, reboots_n = 0;

    // Reflected CRC-32 over one byte, on the finished (inverted) value.
    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] acc;
        acc = ~crc;
        acc[7:0] = acc[7:0] ^ b;
        for (int k = 0; k < 8; k++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return ~acc;
    endfunction

    // Advance the transfer state by one event and return the result it causes.
    function automatic t_out_item receiver_outcome(input t_in_item ev);
        t_out_item r;
        r = '0;
        case (ev.op)
            OP_CONNECT: begin
                st_phase     = PH_HEADER;
                st_hdr_cnt   = '0;
                st_magic_bad = 1'b0;
                st_written   = '0;
                st_crc       = '0;
                st_crc_cnt   = '0;
            end
            OP_DATA: begin
                if (st_phase == PH_HEADER) begin
                    if (st_hdr_cnt < MAGIC_BYTES) begin
                        if (ev.data_byte != MAGIC_SEQ[23 - 8 * st_hdr_cnt -: 8]) begin
                            st_magic_bad = 1'b1;
                        end
                    end else if (st_hdr_cnt >= SIZE_START) begin
                        st_size = {st_size[23:0], ev.data_byte};
                    end
                    st_hdr_cnt = st_hdr_cnt + 4'd1;
                    if (st_hdr_cnt >= HEADER_BYTES) begin
                        st_hdr_cnt = '0;
                        if (st_magic_bad || !cfg_target) begin
                            r.reply_code = RC_ER;
                            r.drop_link  = 1'b1;
                            st_phase     = PH_ERROR;
                        end else begin
                            r.reply_code    = RC_HD;
                            r.erase_request = 1'b1;
                            st_phase        = PH_WRITE;
                        end
                    end
                end else if (st_phase == PH_WRITE) begin
                    if (st_written >= cfg_bytes) begin
                        r.reply_code = RC_ER;
                        r.drop_link  = 1'b1;
                        st_phase     = PH_ERROR;
                    end else begin
                        r.write_valid  = 1'b1;
                        r.write_offset = cfg_offset + st_written;
                        r.write_byte   = ev.data_byte;
                        st_crc         = crc32_update(st_crc, ev.data_byte);
                        st_written     = st_written + 32'd1;
                        if (st_written == st_size) begin
                            r.reply_code = RC_OK;
                            st_phase     = PH_CRCW;
                            st_crc_cnt   = '0;
                        end
                    end
                end else if (st_phase == PH_CRCW) begin
                    st_crc_exp = {st_crc_exp[23:0], ev.data_byte};
                    st_crc_cnt = st_crc_cnt + 3'd1;
                    if (st_crc_cnt >= CRC_BYTES) begin
                        st_crc_cnt  = '0;
                        r.drop_link = 1'b1;
                        if (st_crc_exp == st_crc) begin
                            r.reply_code = RC_CC;
                            st_phase     = PH_DONE;
                        end else begin
                            r.reply_code = RC_ER;
                            st_phase     = PH_ERROR;
                        end
                    end
                end
            end
            OP_ABORT: begin
                r.drop_link = 1'b1;
                st_phase    = PH_ERROR;
            end
            default: begin
                // A close in done asks for the reboot once; otherwise it ends the session.
                if (st_phase == PH_DONE && !st_reboot_sent) begin
                    st_reboot_sent   = 1'b1;
                    r.reboot_request = 1'b1;
                end else begin
                    st_phase   = PH_LISTEN;
                    st_written = '0;
                    st_crc     = '0;
                    st_crc_cnt = '0;
                end
            end
        endcase
        r.phase_now = st_phase;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Stimulus helpers.
    task automatic push_event(input logic [1:0] op, input logic [7:0] b);
        t_in_item ev;
        ev.op        = op;
        ev.data_byte = b;
        tx_backlog.push_back(ev);
        queued_n++;
    endtask

    // Sends the first upto bytes of a header; bad_magic spoils one magic byte.
    task automatic push_header(input bit bad_magic, input logic [31:0] size, input int upto);
        logic [63:0] hdr;
        logic [7:0]  spoil;
        int          pos;
        hdr = {MAGIC_0, MAGIC_1, MAGIC_2, 8'($urandom), size};
        if (bad_magic) begin
            spoil = 8'($urandom_range(1, 255));
            pos   = $urandom_range(0, 2);
            hdr[63 - 8 * pos -: 8] = hdr[63 - 8 * pos -: 8] ^ spoil;
        end
        for (pos = 0; pos < upto; pos++) begin
            push_event(OP_DATA, hdr[63 - 8 * pos -: 8]);
        end
    endtask

    // One client session: mostly well-formed transfers, some noise and broken ones.
    task automatic gen_session();
        int          kind;
        int          n;
        int          cut;
        int          i;
        logic [31:0] size;
        logic [31:0] crc;
        logic [7:0]  b;
        logic [1:0]  rop;
        bit          complete;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            repeat ($urandom_range(1, 4)) begin
                rop = 2'($urandom_range(0, 3));
                b   = 8'($urandom);
                push_event(rop, b);
            end
        end else begin
            b = 8'($urandom);
            push_event(OP_CONNECT, b);
            case ($urandom_range(0, 9))
                0:       size = '0;
                1:       size = (cfg_bytes <= 48) ? cfg_bytes : $urandom_range(1, 48);
                2:       size = (cfg_bytes < 48) ? cfg_bytes + 32'd1 : $urandom;
                3:       size = $urandom;
                default: size = $urandom_range(1, 12);
            endcase
            if (kind == 3) begin
                // Header cut short by an abort or an early close.
                push_header(1'b0, size, $urandom_range(1, HEADER_BYTES - 1));
                rop = $urandom_range(0, 1) ? OP_ABORT : OP_CLOSE;
                push_event(rop, 8'h00);
            end else begin
                push_header(kind == 2, size, HEADER_BYTES);
                if (kind != 2 && cfg_target) begin
                    complete = 1'b0;
                    if (size != 0 && size <= cfg_bytes && size <= 48) begin
                        n        = size;
                        complete = 1'b1;
                    end else if (cfg_bytes <= 48) begin
                        n = cfg_bytes + 1;
                    end else begin
                        n = $urandom_range(2, 10);
                    end
                    cut = (kind == 4) ? $urandom_range(0, n - 1) : n;
                    crc = '0;
                    for (i = 0; i < cut; i++) begin
                        b   = 8'($urandom);
                        crc = crc32_update(crc, b);
                        push_event(OP_DATA, b);
                    end
                    if (cut < n) begin
                        push_event(OP_ABORT, 8'($urandom));
                    end else if (complete) begin
                        if ($urandom_range(0, 3) == 0) begin
                            crc = crc ^ (32'h1 << $urandom_range(0, 31));
                        end
                        for (i = 0; i < CRC_BYTES; i++) begin
                            push_event(OP_DATA, crc[31 - 8 * i -: 8]);
                        end
                    end else begin
                        push_event(OP_CLOSE, 8'($urandom));
                    end
                end
                case ($urandom_range(0, 3))
                    0: push_event(OP_CLOSE, 8'($urandom));
                    1: begin
                        push_event(OP_DATA, 8'($urandom));
                        push_event(OP_CLOSE, 8'($urandom));
                    end
                    2: begin
                        push_event(OP_CLOSE, 8'($urandom));
                        push_event(OP_CLOSE, 8'($urandom));
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // Register write, shadow update and read-back over the APB-style port.
    task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PART_OFFSET: cfg_offset = val;
            REG_PART_BYTES:  cfg_bytes  = val;
            default:         cfg_target = val[0];
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PART_OFFSET: want = cfg_offset;
            REG_PART_BYTES:  want = cfg_bytes;
            default: begin
                want = {31'b0, cfg_target};
                rd   = {31'b0, rd[0]};
            end
        endcase
        check_field("prdata", want, rd);
    endtask

    // Registers change only once the block has finished all earlier work.
    task automatic wait_drained();
        while (tx_backlog.size() != 0 || i_in_valid || predicted_out.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] off, input logic [31:0] nbytes,
                             input logic tgt, input int quota);
        logic [31:0] tval;
        int          start;
        tval    = $urandom;
        tval[0] = tgt;
        program_reg(REG_PART_OFFSET, off);
        program_reg(REG_PART_BYTES, nbytes);
        program_reg(REG_TARGET_OK, tval);
        start = queued_n;
        while (queued_n - start < quota) begin
            gen_session();
        end
        wait_drained();
        settings_n++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_stall) begin
            // Stalled transaction stays on the bus unchanged.
        end else if (gap_left != 0) begin
            i_in_valid <= 1'b0;
            gap_left   <= gap_left - 1;
        end else if (tx_backlog.size() != 0) begin
            i_in_valid <= 1'b1;
            i_in_item  <= tx_backlog.pop_front();
            if (burst_left <= 1) begin
                burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 16);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver: stall pattern switches among none, random, periodic and long holds.
    int stall_mode = 0;
    int hold_left  = 0;

    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ((cycle_count % 7) < 3);
            default: begin
                if (hold_left > 0) begin
                    i_out_stall <= 1'b1;
                    hold_left   <= hold_left - 1;
                end else begin
                    i_out_stall <= 1'b0;
                    if ($urandom_range(0, 9) == 0) begin
                        hold_left <= $urandom_range(1, 20);
                    end
                end
            end
        endcase
        if (cycle_count % 200 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
    end

    // Predict on every accepted input, then check every accepted result.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predicted_out.push_back(receiver_outcome(i_in_item));
                accepted_n++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_n++;
                if (predicted_out.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    mismatches++;
                end else begin
                    want = predicted_out.pop_front();
                    check_field("reply_code", 32'(want.reply_code),
                                32'(o_out_item.reply_code));
                    check_field("erase_request", 32'(want.erase_request),
                                32'(o_out_item.erase_request));
                    check_field("write_valid", 32'(want.write_valid),
                                32'(o_out_item.write_valid));
                    check_field("write_offset", want.write_offset, o_out_item.write_offset);
                    check_field("write_byte", 32'(want.write_byte),
                                32'(o_out_item.write_byte));
                    check_field("drop_link", 32'(want.drop_link),
                                32'(o_out_item.drop_link));
                    check_field("reboot_request", 32'(want.reboot_request),
                                32'(o_out_item.reboot_request));
                    check_field("phase_now", 32'(want.phase_now),
                                32'(o_out_item.phase_now));
                    case (want.reply_code)
                        RC_HD:   hd_n++;
                        RC_OK:   ok_n++;
                        RC_CC:   cc_n++;
                        RC_ER:   er_n++;
                        default: ;
                    endcase
                    if (want.write_valid) writes_n++;
                    if (want.reboot_request) reboots_n++;
                end
            end
        end
    end

    // Cycle count and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Run limit of %0d cycles reached with %0d results outstanding",
                     RUN_LIMIT, predicted_out.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Reset, directed session, then randomized phases under varied settings.
    initial begin
        logic [31:0] dcrc;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: image wraps past the top of the offset range.
        program_reg(REG_PART_OFFSET, 32'hFFFF_FFFE);
        program_reg(REG_PART_BYTES, 32'd64);
        program_reg(REG_TARGET_OK, 32'h0000_0001);
        push_event(OP_DATA, 8'h00);
        push_event(OP_CLOSE, 8'h00);
        push_event(OP_CONNECT, 8'hFF);
        push_event(OP_DATA, MAGIC_0);
        push_event(OP_DATA, MAGIC_1);
        push_event(OP_DATA, MAGIC_2);
        push_event(OP_DATA, 8'hFF);
        push_event(OP_DATA, 8'h00);
        push_event(OP_DATA, 8'h00);
        push_event(OP_DATA, 8'h00);
        push_event(OP_DATA, 8'h04);
        dcrc = '0;
        dcrc = crc32_update(dcrc, 8'h00);
        dcrc = crc32_update(dcrc, 8'hFF);
        dcrc = crc32_update(dcrc, 8'h80);
        dcrc = crc32_update(dcrc, 8'h7F);
        push_event(OP_DATA, 8'h00);
        push_event(OP_DATA, 8'hFF);
        push_event(OP_DATA, 8'h80);
        push_event(OP_DATA, 8'h7F);
        push_event(OP_DATA, dcrc[31:24]);
        push_event(OP_DATA, dcrc[23:16]);
        push_event(OP_DATA, dcrc[15:8]);
        push_event(OP_DATA, dcrc[7:0]);
        // Data in done is ignored; the first close asks for the reboot.
        push_event(OP_DATA, 8'hAA);
        push_event(OP_CLOSE, 8'h00);
        push_event(OP_CLOSE, 8'h00);
        push_event(OP_ABORT, 8'h00);
        push_event(OP_DATA, 8'h55);
        wait_drained();
        settings_n++;

        // Random phases: empty partition, wrapping offset, full-range bound,
        // missing target, top offset and a medium-sized partition.
        run_phase(32'h0000_0000, 32'h0000_0000, 1'b1, 90);
        run_phase(32'hFFFF_FFF0, 32'd32, 1'b1, 160);
        run_phase($urandom, 32'hFFFF_FFFF, 1'b1, 150);
        run_phase($urandom, 32'd20, 1'b0, 60);
        run_phase(32'hFFFF_FFFF, $urandom_range(1, 40), 1'b1, 150);
        run_phase($urandom, $urandom_range(49, 4096), 1'b1, 110);

        $display("Sent %0d events and checked %0d results under %0d register settings.",
                 accepted_n, results_n, settings_n);
        $display("Replies: %0d HD, %0d OK, %0d CC, %0d ER; %0d flash writes, %0d reboot.",
                 hd_n, ok_n, cc_n, er_n, writes_n, reboots_n);
        if (mismatches == 0 && predicted_out.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
